>>> rtl/tbp_pkg.sv
`timescale 1ns / 1ps

package tbp_pkg;

  // Stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned AddrW     = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 40;

  // Output queue depth and its pointer / count widths
  localparam int unsigned OutDepth  = 3;
  localparam int unsigned OutPtrW   = 2;
  localparam int unsigned OutCntW   = 2;

  // 2-bit saturating-style counter states
  localparam logic [1:0] CtrStrongNt = 2'd0;
  localparam logic [1:0] CtrWeakNt   = 2'd1;
  localparam logic [1:0] CtrWeakT    = 2'd2;
  localparam logic [1:0] CtrStrongT  = 2'd3;

  // Reset contents of the tables
  localparam logic [1:0] CtrReset = CtrWeakNt;
  localparam logic [1:0] SelReset = CtrWeakT;

  // One result transaction, predicted_taken in bit 0
  typedef struct packed {
    logic [CountW-1:0] correct_total;
    logic              chosen_correct;
    logic              gshare_predicted;
    logic              bimodal_predicted;
    logic              predicted_taken;
  } out_item_t;

endpackage

>>> rtl/tournament_branch_predictor_core.sv
`timescale 1ns / 1ps

// Tournament branch predictor (bimodal + gshare with a per-address selector),
// trained by resolved branches. Each input transaction carries one resolved
// branch; each one yields exactly one result transaction with the chosen
// prediction, both component predictions, a hit flag and the saturating count
// of hits so far. Throughput is one branch per clock while fewer than three
// results are pending: the tables sit in two synchronous memories, with
// bimodal+selector packed in one and gshare in the other, and one read port and
// one write port each, read at accept and written back in the following cycle,
// with a one-entry bypass covering back-to-back branches that hit the same
// entry. A result passes through stage 1 and then the output queue before it
// is offered on the output; stage 1 plus a three-entry queue hold at most
// three pending results, and s_axis_tready_o drops once three are pending.
// After reset a clearing pass writes every table entry, one per cycle;
// s_axis_tready_o stays low until it finishes.

module tournament_branch_predictor_core #(
  parameter int unsigned INDEX_BITS   = 11,
  parameter int unsigned HISTORY_BITS = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] branch_address, [32] taken, [39:33] zero
  input  logic [tbp_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // master side
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] predicted_taken, [1] bimodal_predicted, [2] gshare_predicted,
  // [3] chosen_correct, [35:4] correct_total, [39:36] zero
  output logic [tbp_pkg::OutTdataW-1:0]  m_axis_tdata_o
);
  import tbp_pkg::*;

  localparam int unsigned Depth = 1 << INDEX_BITS;

  // counter update: right -> strong state, wrong -> weak (a weak state flips)
  function automatic logic [1:0] next_ctr(input logic [1:0] ctr, input logic right,
                                          input logic taken);
    logic [1:0] r;
    if (right) begin
      r = taken ? CtrStrongT : CtrStrongNt;
    end else if (ctr == CtrStrongNt || ctr == CtrWeakT) begin
      r = CtrWeakNt;
    end else begin
      r = CtrWeakT;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- clear pass
  logic                  clr_active_q, clr_active_d;
  logic [INDEX_BITS-1:0] clr_idx_q, clr_idx_d;

  always_comb begin
    clr_idx_d    = clr_idx_q;
    clr_active_d = clr_active_q;
    if (clr_active_q) begin
      clr_idx_d = clr_idx_q + INDEX_BITS'(1);
      if (clr_idx_q == '1) begin
        clr_active_d = 1'b0;
      end
    end
  end

  // ----------------------------------------------------------- accept / index
  logic                    s_fire;
  logic [AddrW-1:0]        in_addr;
  logic                    in_taken;
  logic [INDEX_BITS-1:0]   in_bidx, in_gidx, hist_ix;
  logic [HISTORY_BITS-1:0] hist_q, hist_d;
  logic [HISTORY_BITS:0]   hist_shift;
  logic [OutCntW-1:0]      fifo_count;
  logic [OutCntW:0]        in_flight;
  logic                    s1_valid_q;

  assign in_addr  = s_axis_tdata_i[AddrW-1:0];
  assign in_taken = s_axis_tdata_i[AddrW];
  assign in_bidx  = in_addr[INDEX_BITS-1:0];

  // history truncated or zero-extended to the index width
  if (HISTORY_BITS >= INDEX_BITS) begin : g_hist_trunc
    assign hist_ix = hist_q[INDEX_BITS-1:0];
  end else begin : g_hist_ext
    assign hist_ix = {{(INDEX_BITS - HISTORY_BITS){1'b0}}, hist_q};
  end

  assign in_gidx = in_bidx ^ hist_ix;

  // one slot per item in stage 1 or in the queue; keeps the queue from overflow
  assign in_flight       = {1'b0, fifo_count} + {{OutCntW{1'b0}}, s1_valid_q};
  assign s_axis_tready_o = !clr_active_q && (in_flight < (OutCntW + 1)'(OutDepth));
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;

  // history only depends on outcomes, so it advances right at accept
  assign hist_shift = {hist_q, in_taken};
  assign hist_d     = s_fire ? hist_shift[HISTORY_BITS-1:0] : hist_q;

  // ---------------------------------------------------------------- stage 1
  logic                  s1_taken_q;
  logic [INDEX_BITS-1:0] s1_bidx_q, s1_gidx_q;

  // tables: bc = {selector, bimodal}, gs = gshare
  logic [3:0] bc_mem [Depth];
  logic [1:0] gs_mem [Depth];
  logic [3:0] bc_rd_q;
  logic [1:0] gs_rd_q;

  // bypass of the write issued on the same edge as the current read
  logic                  bc_fwd_vld_q, gs_fwd_vld_q;
  logic [INDEX_BITS-1:0] bc_fwd_addr_q, gs_fwd_addr_q;
  logic [3:0]            bc_fwd_data_q;
  logic [1:0]            gs_fwd_data_q;

  logic [3:0]            bc_cur;
  logic [1:0]            gs_cur;
  logic [1:0]            bctr, gctr, sel, sel_new;
  logic                  bpred, gpred, pred, bright, gright, cright;

  logic                  bc_we, gs_we;
  logic [INDEX_BITS-1:0] bc_waddr, gs_waddr;
  logic [3:0]            bc_wdata, s1_bc_new;
  logic [1:0]            gs_wdata, s1_gs_new;

  logic [CountW-1:0]     correct_q, correct_d;
  out_item_t             s1_item, fifo_data;
  logic                  fifo_valid;

  assign bc_cur = (bc_fwd_vld_q && bc_fwd_addr_q == s1_bidx_q) ? bc_fwd_data_q : bc_rd_q;
  assign gs_cur = (gs_fwd_vld_q && gs_fwd_addr_q == s1_gidx_q) ? gs_fwd_data_q : gs_rd_q;

  always_comb begin
    bctr   = bc_cur[1:0];
    sel    = bc_cur[3:2];
    gctr   = gs_cur;
    bpred  = bctr[1];
    gpred  = gctr[1];
    pred   = sel[1] ? bpred : gpred;
    bright = (bpred == s1_taken_q);
    gright = (gpred == s1_taken_q);
    cright = (pred == s1_taken_q);

    // selector leans toward the component that alone was right
    sel_new = sel;
    if (gright && !bright) begin
      if (sel != 2'd0) begin
        sel_new = sel - 2'd1;
      end
    end else if (bright && !gright) begin
      if (sel != 2'd3) begin
        sel_new = sel + 2'd1;
      end
    end

    s1_bc_new = {sel_new, next_ctr(bctr, bright, s1_taken_q)};
    s1_gs_new = next_ctr(gctr, gright, s1_taken_q);

    correct_d = correct_q;
    if (s1_valid_q && cright && correct_q != '1) begin
      correct_d = correct_q + CountW'(1);
    end

    s1_item.correct_total     = correct_d;
    s1_item.chosen_correct    = cright;
    s1_item.gshare_predicted  = gpred;
    s1_item.bimodal_predicted = bpred;
    s1_item.predicted_taken   = pred;
  end

  // write port: clearing pass owns it until done, then stage 1 write-back
  always_comb begin
    if (clr_active_q) begin
      bc_we    = 1'b1;
      bc_waddr = clr_idx_q;
      bc_wdata = {SelReset, CtrReset};
      gs_we    = 1'b1;
      gs_waddr = clr_idx_q;
      gs_wdata = CtrReset;
    end else begin
      bc_we    = s1_valid_q;
      bc_waddr = s1_bidx_q;
      bc_wdata = s1_bc_new;
      gs_we    = s1_valid_q;
      gs_waddr = s1_gidx_q;
      gs_wdata = s1_gs_new;
    end
  end

  // memories: read-before-write on a shared address, hence the bypass
  always_ff @(posedge clk_i) begin
    if (bc_we) begin
      bc_mem[bc_waddr] <= bc_wdata;
    end
    if (s_fire) begin
      bc_rd_q <= bc_mem[in_bidx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (gs_we) begin
      gs_mem[gs_waddr] <= gs_wdata;
    end
    if (s_fire) begin
      gs_rd_q <= gs_mem[in_gidx];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
      hist_q       <= '0;
      s1_valid_q   <= 1'b0;
      bc_fwd_vld_q <= 1'b0;
      gs_fwd_vld_q <= 1'b0;
      correct_q    <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_idx_q    <= clr_idx_d;
      hist_q       <= hist_d;
      s1_valid_q   <= s_fire;
      bc_fwd_vld_q <= s1_valid_q;
      gs_fwd_vld_q <= s1_valid_q;
      correct_q    <= correct_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_taken_q <= in_taken;
      s1_bidx_q  <= in_bidx;
      s1_gidx_q  <= in_gidx;
    end
    bc_fwd_addr_q <= s1_bidx_q;
    bc_fwd_data_q <= s1_bc_new;
    gs_fwd_addr_q <= s1_gidx_q;
    gs_fwd_data_q <= s1_gs_new;
  end

  // ------------------------------------------------------------ result queue
  tbp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (s1_item),
    .pop_ready_i (m_axis_tready_i),
    .valid_o     (fifo_valid),
    .data_o      (fifo_data),
    .count_o     (fifo_count)
  );

  assign m_axis_tvalid_o = fifo_valid;
  assign m_axis_tdata_o  = {{(OutTdataW - $bits(out_item_t)){1'b0}}, fifo_data};

endmodule

>>> rtl/tbp_out_fifo.sv
`timescale 1ns / 1ps

module tbp_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tbp_pkg::out_item_t push_data_i,
  input  logic              pop_ready_i,
  output logic              valid_o,
  output tbp_pkg::out_item_t data_o,
  output logic [tbp_pkg::OutCntW-1:0] count_o
);
  import tbp_pkg::*;

  out_item_t          mem_q [OutDepth];
  logic [OutPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OutPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OutCntW-1:0] count_q, count_d;
  logic               pop;

  function automatic logic [OutPtrW-1:0] ptr_inc(input logic [OutPtrW-1:0] p);
    logic [OutPtrW-1:0] r;
    if (p == OutPtrW'(OutDepth - 1)) begin
      r = '0;
    end else begin
      r = p + OutPtrW'(1);
    end
    return r;
  endfunction

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign pop     = valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + OutCntW'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - OutCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tbp_pkg::*;

  localparam int unsigned INDEX_BITS   = 11;
  localparam int unsigned HISTORY_BITS = 11;
  localparam int unsigned TableDepth   = 1 << INDEX_BITS;
  localparam logic [AddrW-1:0] IndexMask = (AddrW'(1) << INDEX_BITS) - 1;
  // Covers the clearing pass, the long output hold-off and deep stalls.
  localparam int WatchdogLimit = 20000;
  localparam int HoldOffCycles = 300;
  localparam int ItemsPerPhase = 207;
  localparam int MaxReports    = 40;

  typedef logic [INDEX_BITS-1:0]   idx_t;
  typedef logic [HISTORY_BITS-1:0] hist_t;

  // Shapes of the recurring branches in the random traffic.
  typedef enum int {BrBiasTaken, BrBiasNotTaken, BrLoop, BrCorrelated} branch_kind_e;

  // Tournament predictor mirror plus the queue of predictions still owed by the block.
  class tournament_model;
    logic [1:0]  bim_ctr [TableDepth];
    logic [1:0]  gsh_ctr [TableDepth];
    logic [1:0]  sel_ctr [TableDepth];
    hist_t       ghist;
    logic [CountW-1:0] hits;
    out_item_t   pending_predictions[$];
    int          mismatches;
    int          branches;
    int          results;

    function new();
      foreach (bim_ctr[i]) begin
        bim_ctr[i] = CtrReset;
        gsh_ctr[i] = CtrReset;
        sel_ctr[i] = SelReset;
      end
      ghist = '0;
      hits = '0;
      mismatches = 0;
      branches = 0;
      results = 0;
    endfunction

    // Right guess jumps to strong, wrong guess to weak (a weak state flips its side).
    function logic [1:0] trained(logic [1:0] ctr, logic right, logic taken);
      if (right) return taken ? CtrStrongT : CtrStrongNt;
      return (ctr == CtrStrongNt || ctr == CtrWeakT) ? CtrWeakNt : CtrWeakT;
    endfunction

    function void train(logic [AddrW-1:0] addr, logic taken);
      idx_t       bidx;
      idx_t       gidx;
      logic [1:0] bc;
      logic [1:0] gc;
      logic [1:0] sc;
      logic       bp;
      logic       gp;
      logic       pred;
      logic       br;
      logic       gr;
      out_item_t  exp;
      bidx = addr[INDEX_BITS-1:0];
      gidx = bidx ^ idx_t'(ghist);
      bc = bim_ctr[bidx];
      gc = gsh_ctr[gidx];
      sc = sel_ctr[bidx];
      bp = bc >= CtrWeakT;
      gp = gc >= CtrWeakT;
      pred = (sc >= CtrWeakT) ? bp : gp;
      br = bp == taken;
      gr = gp == taken;
      if (pred == taken && hits != '1) hits++;
      gsh_ctr[gidx] = trained(gc, gr, taken);
      bim_ctr[bidx] = trained(bc, br, taken);
      // Selector leans toward whichever component alone got it right.
      if (gr && !br) begin
        if (sc != CtrStrongNt) sc--;
      end else if (br && !gr) begin
        if (sc != CtrStrongT) sc++;
      end
      sel_ctr[bidx] = sc;
      ghist = hist_t'({ghist, taken});
      exp.predicted_taken   = pred;
      exp.bimodal_predicted = bp;
      exp.gshare_predicted  = gp;
      exp.chosen_correct    = pred == taken;
      exp.correct_total     = hits;
      pending_predictions.insert(pending_predictions.size(), exp);
      branches++;
    endfunction

    function void report(string field, logic [CountW-1:0] exp_v, logic [CountW-1:0] got_v);
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, got_v);
    endfunction

    function void check_prediction(out_item_t got);
      out_item_t exp;
      results++;
      if (pending_predictions.size() == 0) begin
        report("unexpected result", '0, got.correct_total);
        return;
      end
      exp = pending_predictions.pop_front();
      if (got.predicted_taken != exp.predicted_taken)
        report("predicted_taken", exp.predicted_taken, got.predicted_taken);
      if (got.bimodal_predicted != exp.bimodal_predicted)
        report("bimodal_predicted", exp.bimodal_predicted, got.bimodal_predicted);
      if (got.gshare_predicted != exp.gshare_predicted)
        report("gshare_predicted", exp.gshare_predicted, got.gshare_predicted);
      if (got.chosen_correct != exp.chosen_correct)
        report("chosen_correct", exp.chosen_correct, got.chosen_correct);
      if (got.correct_total != exp.correct_total)
        report("correct_total", exp.correct_total, got.correct_total);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;

  tournament_model model;
  int  idle_pct = 0;
  int  stall_pct = 0;
  int  hold_off_cycles = 0;
  int  quiet_cycles = 0;

  // Recurring branches: fixed low bits so they keep training the same entries.
  logic [AddrW-1:0] hot_addr [16];
  branch_kind_e     hot_kind [16];
  int               hot_trip [16];
  int               hot_iter [16];
  logic [1:0]       recent_outcomes = '0;

  tournament_branch_predictor_core #(
    .INDEX_BITS  (INDEX_BITS),
    .HISTORY_BITS(HISTORY_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long counted hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_off_cycles--;
    end else begin
      m_axis_tready_i <= $urandom_range(99) >= stall_pct;
    end
  end

  // Monitor: predicts on each accepted branch, checks each accepted result, and
  // ends the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o)
      model.train(s_axis_tdata_i[AddrW-1:0], s_axis_tdata_i[AddrW]);
    if (m_axis_tvalid_o && m_axis_tready_i)
      model.check_prediction(out_item_t'(m_axis_tdata_o[$bits(out_item_t)-1:0]));
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_branch(input logic [AddrW-1:0] addr, input logic taken);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(InTdataW-AddrW-1){1'b0}}, taken, addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Mostly recurring branches with learnable behavior, the rest random noise.
  task automatic next_branch(output logic [AddrW-1:0] addr, output logic taken);
    int slot;
    if ($urandom_range(99) < 25) begin
      addr  = $urandom();
      taken = 1'($urandom_range(1));
    end else begin
      slot = $urandom_range(15);
      addr = hot_addr[slot];
      // Upper address bits must not change the entry used.
      if ($urandom_range(3) == 0) addr ^= $urandom() & ~IndexMask;
      case (hot_kind[slot])
        BrBiasTaken:    taken = $urandom_range(9) != 0;
        BrBiasNotTaken: taken = $urandom_range(9) == 0;
        BrLoop: begin
          hot_iter[slot]++;
          taken = (hot_iter[slot] % hot_trip[slot]) != 0;
        end
        default:        taken = recent_outcomes[1] ^ recent_outcomes[0];
      endcase
    end
    recent_outcomes = {recent_outcomes[0], taken};
  endtask

  initial begin
    logic [AddrW-1:0] addr;
    logic             taken;
    model = new();
    for (int i = 0; i < 16; i++) begin
      hot_addr[i] = $urandom();
      hot_kind[i] = branch_kind_e'(i % 4);
      hot_trip[i] = $urandom_range(2, 7);
      hot_iter[i] = 0;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: address extremes, ignored upper bits, a short loop, and one
    // entry reached through many different upper-bit patterns.
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_F800, 1'b1);
    send_branch(32'h0000_07FF, 1'b1);
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h5555_5555, 1'b0);
    send_branch(32'h8000_0001, 1'b1);
    for (int i = 0; i < 8; i++) send_branch(32'h0000_0100, (i % 3) != 2);
    for (int i = 0; i < 8; i++)
      send_branch(32'h1234_5678 ^ (AddrW'(i) << (INDEX_BITS + 3)), i[0]);

    // Random phases: free flow (opening with a long output hold-off), sparse
    // input, heavy output back-pressure, then both sides throttled.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_off_cycles = HoldOffCycles; end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      repeat (ItemsPerPhase) begin
        next_branch(addr, taken);
        send_branch(addr, taken);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (model.pending_predictions.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Trained %0d branches, checked %0d results, %0d chosen predictions right.",
             model.branches, model.results, model.hits);
    $display("Phases: directed, %0d-cycle hold-off, sparse, stalled, mixed; %0d mismatches.",
             HoldOffCycles, model.mismatches);
    if (model.mismatches == 0 && model.pending_predictions.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> tournament_branch_predictor_core.f
rtl/tbp_pkg.sv
rtl/tbp_out_fifo.sv
rtl/tournament_branch_predictor_core.sv
tb/tb_top.sv
